/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/sld_pkg.sv */
// ----------------------------------------------------------------------------
// sld_pkg
// Shared widths, codes, register map and control types of the span draw unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sld_pkg;

	localparam int MAX_PIXELS = 1024;
	localparam int PIX_AW     = $clog2(MAX_PIXELS);
	localparam int CNT_W      = PIX_AW + 1;

	localparam int CMD_W   = 2;
	localparam int POS_W   = 23;
	localparam int SPAN_W  = 16;
	localparam int RGB_W   = 24;
	localparam int CH_W    = 8;
	localparam int LOC_W   = 16;
	localparam int TOUCH_W = 16;
	localparam int FRAC_W  = 3;
	localparam int BLEND_W = 2;
	localparam int ALPHA_W = 8;
	localparam int LEN_W   = 11;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	// commands
	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// blend modes; the unused code acts as saturating add
	localparam logic [BLEND_W-1:0] BLEND_COPY = 2'd0;
	localparam logic [BLEND_W-1:0] BLEND_MAX  = 2'd1;
	localparam logic [BLEND_W-1:0] BLEND_ADD  = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_FRAC  = 3'd0;
	localparam logic [2:0] REG_WRAP  = 3'd1;
	localparam logic [2:0] REG_BLEND = 3'd2;
	localparam logic [2:0] REG_ALPHA = 3'd3;
	localparam logic [2:0] REG_LEN   = 3'd4;

	localparam logic [FRAC_W-1:0]  FRAC_RST  = 3'd4;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 8'hff;
	localparam logic [LEN_W-1:0]   LEN_RST   = 11'd1024;

	typedef struct packed {
		logic [FRAC_W-1:0]  frac_bits;
		logic               wrap_enable;
		logic [BLEND_W-1:0] blend_mode;
		logic [ALPHA_W-1:0] global_alpha;
		logic [LEN_W-1:0]   strip_length;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic mod_start;
		logic mod_take;
		logic step;
		logic mul;
		logic wr_pix;
		logic adv;
		logic wr_cmd;
		logic rd_take;
		logic clr;
		logic fin;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             width_zero;
		logic             count_zero;
		logic             wrap;
		logic             map_ok;
		logic             mod_busy;
		logic             clr_last;
	} dp_sts_t;

endpackage

`default_nettype wire

/* design/sld_in_if.sv */
// ----------------------------------------------------------------------------
// sld_in_if
// Command channel: valid/ready with one draw, write or read command.
// ----------------------------------------------------------------------------
`default_nettype none

interface sld_in_if;
	logic                        valid;
	logic                        ready;
	logic [sld_pkg::CMD_W-1:0]   cmd;
	logic [sld_pkg::POS_W-1:0]   start_pos;
	logic [sld_pkg::SPAN_W-1:0]  span_width;
	logic [sld_pkg::RGB_W-1:0]   rgb_in;
	logic [sld_pkg::PIX_AW-1:0]  pixel_addr;

	modport source (
		output valid, cmd, start_pos, span_width, rgb_in, pixel_addr,
		input  ready
	);
	modport sink (
		input  valid, cmd, start_pos, span_width, rgb_in, pixel_addr,
		output ready
	);
endinterface

`default_nettype wire

/* design/sld_out_if.sv */
// ----------------------------------------------------------------------------
// sld_out_if
// Result channel: valid/ready with read color and touched pixel count.
// ----------------------------------------------------------------------------
`default_nettype none

interface sld_out_if;
	logic                         valid;
	logic                         ready;
	logic [sld_pkg::RGB_W-1:0]    rgb_out;
	logic [sld_pkg::TOUCH_W-1:0]  pixels_touched;

	modport source (
		output valid, rgb_out, pixels_touched,
		input  ready
	);
	modport sink (
		input  valid, rgb_out, pixels_touched,
		output ready
	);
endinterface

`default_nettype wire

/* design/sld_regs.sv */
// ----------------------------------------------------------------------------
// sld_regs
// APB configuration registers; zero wait states, reads return the register.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sld_pkg::APB_AW-1:0]   paddr,
	input  logic [sld_pkg::APB_DW-1:0]   pwdata,
	output logic [sld_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output sld_pkg::cfg_t                cfg
);
	import sld_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frac_bits    <= FRAC_RST;
			cfg_q.wrap_enable  <= 1'b0;
			cfg_q.blend_mode   <= BLEND_COPY;
			cfg_q.global_alpha <= ALPHA_RST;
			cfg_q.strip_length <= LEN_RST;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_FRAC:  cfg_q.frac_bits    <= pwdata[FRAC_W-1:0];
				REG_WRAP:  cfg_q.wrap_enable  <= pwdata[0];
				REG_BLEND: cfg_q.blend_mode   <= pwdata[BLEND_W-1:0];
				REG_ALPHA: cfg_q.global_alpha <= pwdata[ALPHA_W-1:0];
				REG_LEN:   cfg_q.strip_length <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_FRAC:  prdata = APB_DW'(cfg_q.frac_bits);
			REG_WRAP:  prdata = APB_DW'(cfg_q.wrap_enable);
			REG_BLEND: prdata = APB_DW'(cfg_q.blend_mode);
			REG_ALPHA: prdata = APB_DW'(cfg_q.global_alpha);
			REG_LEN:   prdata = APB_DW'(cfg_q.strip_length);
			default:   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* design/sld_mod.sv */
// ----------------------------------------------------------------------------
// sld_mod
// Restoring remainder unit: 16-bit index modulo pixel count, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sld_pkg::LOC_W-1:0]    dividend,
	input  logic [sld_pkg::CNT_W-1:0]    divisor,
	output logic                         busy,
	output logic [sld_pkg::PIX_AW-1:0]   rem
);
	import sld_pkg::*;

	localparam int STEP_W = $clog2(LOC_W);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [LOC_W-1:0]  num_q;
	logic [PIX_AW-1:0] rem_q;
	logic [CNT_W-1:0]  trial;
	logic [CNT_W-1:0]  trial_red;

	// remainder stays below the divisor, so it fits the slot width
	assign trial     = {rem_q, num_q[LOC_W-1]};
	assign trial_red = (trial >= divisor) ? (trial - divisor) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == STEP_W'(LOC_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[LOC_W-2:0], 1'b0};
			rem_q <= trial_red[PIX_AW-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* design/sld_dp.sv */
// ----------------------------------------------------------------------------
// sld_dp
// Datapath: pixel store, span walker registers, scale/blend pipe, results.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sld_pkg::cfg_t                cfg,
	input  sld_pkg::dp_cmd_t             dcmd,
	output sld_pkg::dp_sts_t             sts,
	input  logic [sld_pkg::CMD_W-1:0]    cmd,
	input  logic [sld_pkg::POS_W-1:0]    start_pos,
	input  logic [sld_pkg::SPAN_W-1:0]   span_width,
	input  logic [sld_pkg::RGB_W-1:0]    rgb_in,
	input  logic [sld_pkg::PIX_AW-1:0]   pixel_addr,
	output logic [sld_pkg::RGB_W-1:0]    rgb_out,
	output logic [sld_pkg::TOUCH_W-1:0]  pixels_touched
);
	import sld_pkg::*;

	localparam int NCH  = RGB_W / CH_W;
	localparam int P1_W = 2 * CH_W;
	localparam int P2_W = P1_W + ALPHA_W;

	// floor(x / 255), exact while the quotient fits 8 bits (x below 65280)
	function automatic logic [CH_W-1:0] div255(input logic [P1_W-1:0] x);
		logic [P1_W:0] s;
		s = {1'b0, x} + (P1_W+1)'(x[P1_W-1:CH_W]) + (P1_W+1)'(1);
		return s[P1_W-1:CH_W];
	endfunction

	logic [RGB_W-1:0] mem [MAX_PIXELS];
	logic [RGB_W-1:0] rdata_q;

	logic [CMD_W-1:0]   cmd_q;
	logic [RGB_W-1:0]   color_q;
	logic [SPAN_W-1:0]  width_q;
	logic [CH_W-1:0]    remain_q;
	logic [LOC_W-1:0]   loc_q;
	logic [TOUCH_W-1:0] touched_q;
	logic [RGB_W-1:0]   rgb_res_q;
	logic [RGB_W-1:0]   out_rgb_q;
	logic [TOUCH_W-1:0] out_touched_q;
	logic [PIX_AW-1:0]  clr_q;
	logic [P1_W-1:0]    prod1_q [NCH];
	logic [P2_W-1:0]    prod2_q [NCH];

	logic [CNT_W-1:0]  count;
	logic [LOC_W-1:0]  count_ext;
	logic [CH_W-1:0]   one;
	logic [POS_W-1:0]  pos_sh;
	logic [CH_W-1:0]   amount;
	logic [LOC_W-1:0]  loc_inc;
	logic [LOC_W-1:0]  loc_nxt;
	logic              map_ok;
	logic [PIX_AW-1:0] slot;
	logic              mod_busy;
	logic [PIX_AW-1:0] mod_rem;

	logic [P2_W-1:0]  sh_ch  [NCH];
	logic [CH_W-1:0]  src_ch [NCH];
	logic [CH_W:0]    sum_ch [NCH];
	logic [RGB_W-1:0] blended;

	logic              we;
	logic [PIX_AW-1:0] waddr;
	logic [RGB_W-1:0]  wdata;

	assign count = (int'(cfg.strip_length) > MAX_PIXELS) ? CNT_W'(MAX_PIXELS)
	                                                     : CNT_W'(cfg.strip_length);
	assign count_ext = LOC_W'(count);
	assign one       = CH_W'(1) << cfg.frac_bits;
	assign pos_sh    = start_pos >> cfg.frac_bits;
	assign amount    = (width_q < SPAN_W'(remain_q)) ? width_q[CH_W-1:0] : remain_q;

	// with wrap the index is already reduced, so one step back to zero suffices
	assign loc_inc = loc_q + LOC_W'(1);
	assign loc_nxt = (cfg.wrap_enable && loc_inc == count_ext) ? '0 : loc_inc;
	assign map_ok  = (count != '0) && (cfg.wrap_enable || loc_q < count_ext);
	assign slot    = loc_q[PIX_AW-1:0];

	sld_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dcmd.mod_start),
		.dividend (loc_q),
		.divisor  (count),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			sh_ch[i]  = prod2_q[i] >> cfg.frac_bits;
			src_ch[i] = div255(sh_ch[i][P1_W-1:0]);
			sum_ch[i] = {1'b0, src_ch[i]} + {1'b0, rdata_q[i*CH_W +: CH_W]};
			case (cfg.blend_mode)
				BLEND_COPY: blended[i*CH_W +: CH_W] = src_ch[i];
				BLEND_MAX:  blended[i*CH_W +: CH_W] =
					(src_ch[i] > rdata_q[i*CH_W +: CH_W]) ? src_ch[i]
					                                     : rdata_q[i*CH_W +: CH_W];
				default:    blended[i*CH_W +: CH_W] =
					sum_ch[i][CH_W] ? {CH_W{1'b1}} : sum_ch[i][CH_W-1:0];
			endcase
		end
	end

	always_comb begin
		we    = dcmd.clr || dcmd.wr_pix || (dcmd.wr_cmd && map_ok);
		waddr = slot;
		wdata = color_q;
		if (dcmd.clr) begin
			waddr = clr_q;
			wdata = '0;
		end else if (dcmd.wr_pix) begin
			wdata = blended;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (dcmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q     <= cmd;
			color_q   <= rgb_in;
			width_q   <= span_width;
			remain_q  <= one - (start_pos[CH_W-1:0] & (one - CH_W'(1)));
			touched_q <= '0;
			rgb_res_q <= '0;
			if (cmd == CMD_DRAW) begin
				loc_q <= pos_sh[LOC_W-1:0];
			end else begin
				loc_q <= LOC_W'(pixel_addr);
			end
		end
		if (dcmd.mod_take) begin
			loc_q <= LOC_W'(mod_rem);
		end
		if (dcmd.step) begin
			width_q  <= width_q - SPAN_W'(amount);
			remain_q <= one;
			for (int i = 0; i < NCH; i++) begin
				prod1_q[i] <= P1_W'(color_q[i*CH_W +: CH_W]) * P1_W'(amount);
			end
		end
		if (dcmd.mul) begin
			for (int i = 0; i < NCH; i++) begin
				prod2_q[i] <= P2_W'(prod1_q[i]) * P2_W'(cfg.global_alpha);
			end
		end
		if (dcmd.wr_pix) begin
			touched_q <= touched_q + 1'b1;
		end
		if (dcmd.adv || dcmd.wr_pix) begin
			loc_q <= loc_nxt;
		end
		if (dcmd.rd_take) begin
			rgb_res_q <= map_ok ? rdata_q : '0;
		end
		if (dcmd.fin) begin
			out_rgb_q     <= rgb_res_q;
			out_touched_q <= touched_q;
		end
	end

	assign sts.cmd        = cmd_q;
	assign sts.width_zero = (width_q == '0);
	assign sts.count_zero = (count == '0);
	assign sts.wrap       = cfg.wrap_enable;
	assign sts.map_ok     = map_ok;
	assign sts.mod_busy   = mod_busy;
	assign sts.clr_last   = (clr_q == PIX_AW'(MAX_PIXELS - 1));

	assign rgb_out        = out_rgb_q;
	assign pixels_touched = out_touched_q;

endmodule

`default_nettype wire

/* design/sld_ctrl.sv */
// ----------------------------------------------------------------------------
// sld_ctrl
// Controller: store clear after reset, command dispatch, span walk sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sld_pkg::dp_sts_t  sts,
	output sld_pkg::dp_cmd_t  dcmd
);
	import sld_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISP,
		ST_MODW,
		ST_STEP,
		ST_MUL,
		ST_WR,
		ST_RW,
		ST_RDLAT,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		dcmd = '0;
		case (state_q)
			ST_CLEAR: dcmd.clr  = 1'b1;
			ST_IDLE:  dcmd.load = in_valid;
			ST_DISP: begin
				case (sts.cmd)
					CMD_DRAW:
						dcmd.mod_start = sts.wrap && !sts.width_zero && !sts.count_zero;
					CMD_WRITE, CMD_READ:
						dcmd.mod_start = sts.wrap && !sts.count_zero;
					default: ;
				endcase
			end
			ST_MODW: dcmd.mod_take = !sts.mod_busy;
			ST_STEP: begin
				dcmd.step = !sts.width_zero;
				dcmd.adv  = !sts.width_zero && !sts.map_ok;
			end
			ST_MUL:   dcmd.mul     = 1'b1;
			ST_WR:    dcmd.wr_pix  = 1'b1;
			ST_RW:    dcmd.wr_cmd  = (sts.cmd == CMD_WRITE);
			ST_RDLAT: dcmd.rd_take = 1'b1;
			ST_FIN:   dcmd.fin     = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					case (sts.cmd)
						CMD_DRAW: begin
							if (sts.width_zero || sts.count_zero) begin
								state_q <= ST_FIN;
							end else if (sts.wrap) begin
								state_q <= ST_MODW;
							end else begin
								state_q <= ST_STEP;
							end
						end
						CMD_WRITE, CMD_READ: begin
							if (sts.count_zero) begin
								state_q <= ST_FIN;
							end else if (sts.wrap) begin
								state_q <= ST_MODW;
							end else begin
								state_q <= ST_RW;
							end
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_MODW: begin
					if (!sts.mod_busy) begin
						state_q <= (sts.cmd == CMD_DRAW) ? ST_STEP : ST_RW;
					end
				end
				ST_STEP: begin
					if (sts.width_zero) begin
						state_q <= ST_FIN;
					end else if (sts.map_ok) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_WR;
				ST_WR:  state_q <= ST_STEP;
				ST_RW:  state_q <= (sts.cmd == CMD_READ) ? ST_RDLAT : ST_FIN;
				ST_RDLAT: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/subpixel_led_span_draw_unit.sv */
// Accept to result valid: a read passes dispatch, read/write, read capture and finish; a write
// skips read capture; an unused command ends after dispatch. A draw takes step, multiply and
// write per stored pixel through the store's single read-modify-write path, and just a step per
// pixel outside the strip, then finish; a zero width or pixel count ends after dispatch. With
// wrap a modulo wait follows dispatch; output stalls hold finish. One command at a time, taken
// while a result waits. Reset: asynchronous; the 1024-entry store is then zeroed, no commands.
// ----------------------------------------------------------------------------
// subpixel_led_span_draw_unit
// Antialiased sub-pixel span fill with alpha scaling and blend into a strip store.
// ----------------------------------------------------------------------------
`default_nettype none

module subpixel_led_span_draw_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	sld_in_if.sink                       in_ch,
	sld_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sld_pkg::APB_AW-1:0]   paddr,
	input  logic [sld_pkg::APB_DW-1:0]   pwdata,
	output logic [sld_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import sld_pkg::*;

	cfg_t    cfg;
	dp_cmd_t dcmd;
	dp_sts_t sts;

	sld_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.dcmd      (dcmd)
	);

	sld_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.dcmd           (dcmd),
		.sts            (sts),
		.cmd            (in_ch.cmd),
		.start_pos      (in_ch.start_pos),
		.span_width     (in_ch.span_width),
		.rgb_in         (in_ch.rgb_in),
		.pixel_addr     (in_ch.pixel_addr),
		.rgb_out        (out_ch.rgb_out),
		.pixels_touched (out_ch.pixels_touched)
	);

endmodule

`default_nettype wire

/* design/sld_checker.sv */
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks of the span draw unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sld_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	sld_in_if.sink                       in_ch,
	sld_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sld_pkg::APB_AW-1:0]   paddr,
	input  logic [sld_pkg::APB_DW-1:0]   pwdata,
	input  logic [sld_pkg::APB_DW-1:0]   prdata,
	input  logic                         pready
);
	import sld_pkg::*;

	// one command in flight: busy right after a transaction is taken
	`SLD_ASSERT(a_busy_after_accept, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "ready after accept")

	// a stalled result holds
	`SLD_ASSERT(a_out_hold, (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.rgb_out) && $stable(out_ch.pixels_touched)), "result changed while stalled")

	// read results never report touched pixels, draws never report a color
	`SLD_ASSERT_ALWAYS(a_result_kind, (out_ch.valid && out_ch.rgb_out != '0) |-> (out_ch.pixels_touched == '0), "color and count both set")

	// alpha register reads back what was written
	`SLD_ASSERT(a_alpha_rb, (psel && penable && pwrite && pready && paddr[4:2] == REG_ALPHA) |=> (paddr[4:2] != REG_ALPHA || prdata[ALPHA_W-1:0] == $past(pwdata[ALPHA_W-1:0])), "alpha readback mismatch")

endmodule

bind subpixel_led_span_draw_unit sld_checker u_sld_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.in_ch   (in_ch),
	.out_ch  (out_ch),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.pready  (pready)
);

`default_nettype wire
